@@ design/integer_to_base_digits_assert.svh @@
// ----------------------------------------------------------------------------
// integer_to_base_digits assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_BASE_DIGITS_ASSERT_SVH
`define INTEGER_TO_BASE_DIGITS_ASSERT_SVH

// same-cycle implication
`define ITBD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("itbd assertion failed");

// next-cycle implication
`define ITBD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("itbd assertion failed");

`endif

@@ design/itbd_pkg.sv @@
// ----------------------------------------------------------------------------
// itbd_pkg
// Widths, constants, character table and control structs for the converter.
// ----------------------------------------------------------------------------
package itbd_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int RADIX_BITS     = 5;
   localparam int DIGIT_BITS     = 4;
   localparam int CHAR_BITS      = 8;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd16;

   // long division: dividend bits consumed per cycle
   localparam int BITS_PER_STEP  = 8;
   localparam int DIV_CYCLES     = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int MAG_BITS       = DIV_CYCLES * BITS_PER_STEP;
   localparam int STEP_CNT_BITS  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   localparam int MAX_DIGITS     = VALUE_BITS;
   localparam int DIGIT_CNT_BITS = $clog2(MAX_DIGITS + 1);
   localparam int DIGIT_IDX_BITS = $clog2(MAX_DIGITS);

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIGIT_BASE = 1'b0;

   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;

   localparam logic [CHAR_BITS-1:0] DIGIT_CHARS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      return DIGIT_CHARS[d];
   endfunction

   typedef struct packed {
      logic load;
      logic div_step;
      logic div_last;
      logic emit_sign;
      logic emit_digit;
   } dp_cmd_type;

   typedef struct packed {
      logic quot_zero;
      logic negative;
      logic last_digit;
      logic slot_free;
   } dp_status_type;

endpackage

@@ design/itbd_req_if.sv @@
// ----------------------------------------------------------------------------
// itbd_req_if
// Input channel: one signed integer per transfer.
// ----------------------------------------------------------------------------
interface itbd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [itbd_pkg::VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

@@ design/itbd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// itbd_rsp_if
// Result channel: one ASCII character per transfer, last flag on the final one.
// ----------------------------------------------------------------------------
interface itbd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [itbd_pkg::CHAR_BITS-1:0]     char_code;
   logic                               last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ design/integer_to_base_digits.sv @@
// ----------------------------------------------------------------------------
// integer_to_base_digits
// Signed integer to ASCII text in radix 2..16, one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one signed value per transfer; rsp_chan returns its
//   text, most significant character first: '-' for negatives, then digits
//   '0'-'9','a'-'f', last_char high on the final character. Zero gives "0".
//   digit_base sits at byte address 0 on the APB port (reset 16); 0 and 1
//   act as 2, 17..31 act as 16. Write it only while the block is idle.
// Operation:
//   the long divider consumes 8 dividend bits per cycle and pushes one digit
//   each time the whole magnitude has passed through; once the quotient is
//   zero the sign, if negative, and the digits follow, one character per cycle
//   while rsp_chan.ready does not stall the output register.
//   One item is in work at a time; the next is accepted while the final
//   character still waits in the output register.
// Reset: synchronous; clears the controller, drops rsp valid, radix to 16.
// Stall: a held rsp_chan.ready freezes the output register and the digit
//   stack; nothing is lost.
// ----------------------------------------------------------------------------
module integer_to_base_digits (
   input  logic                                 clock,
   input  logic                                 reset,
   itbd_req_if.sink                             req_chan,
   itbd_rsp_if.source                           rsp_chan,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [itbd_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [itbd_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [itbd_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);

   logic [itbd_pkg::RADIX_BITS-1:0]     digit_base_ff;
   logic [itbd_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic                                csr_write;
   itbd_pkg::dp_cmd_type                cmd;
   itbd_pkg::dp_status_type             status;

   assign pready    = 1'b1;
   assign csr_index = paddr[itbd_pkg::CSR_ADDR_BITS-1:2];
   assign csr_write = psel && penable && pwrite && pready
                      && (csr_index == itbd_pkg::REG_DIGIT_BASE);

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_base_ff <= itbd_pkg::RADIX_RESET;
      end else if (csr_write) begin
         digit_base_ff <= pwdata[itbd_pkg::RADIX_BITS-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_index == itbd_pkg::REG_DIGIT_BASE) begin
         prdata = itbd_pkg::CSR_DATA_BITS'(digit_base_ff);
      end
   end

   itbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   itbd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .digit_base    (digit_base_ff),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_chan.value),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_char_code (rsp_chan.char_code),
      .rsp_last_char (rsp_chan.last_char)
   );

endmodule

@@ design/itbd_dp.sv @@
// ----------------------------------------------------------------------------
// itbd_dp
// Datapath: magnitude/sign capture, radix long divider, digit stack and
// output character register.
// ----------------------------------------------------------------------------
`include "integer_to_base_digits_assert.svh"

module itbd_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [itbd_pkg::RADIX_BITS-1:0]        digit_base,
   input  itbd_pkg::dp_cmd_type                   cmd,
   output itbd_pkg::dp_status_type                status,
   input  logic signed [itbd_pkg::VALUE_BITS-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [itbd_pkg::CHAR_BITS-1:0]         rsp_char_code,
   output logic                                   rsp_last_char
);

   logic [itbd_pkg::MAG_BITS-1:0]        mag_ff, mag_in, quot;
   logic                                 neg_ff;
   logic [itbd_pkg::RADIX_BITS-1:0]      radix_ff, radix_in;
   logic [itbd_pkg::RADIX_BITS-1:0]      rem_ff, rem_in, rem_v;
   logic [itbd_pkg::BITS_PER_STEP-1:0]   qbits;
   logic [itbd_pkg::VALUE_BITS-1:0]      raw_abs;
   logic [itbd_pkg::DIGIT_CNT_BITS-1:0]  ndig_ff, ndig_in, ndig_dec;
   logic [itbd_pkg::DIGIT_BITS-1:0]      digits_ff [itbd_pkg::MAX_DIGITS];
   logic [itbd_pkg::DIGIT_BITS-1:0]      top_digit;
   logic                                 rsp_valid_ff, rsp_last_ff;
   logic [itbd_pkg::CHAR_BITS-1:0]       rsp_char_ff;
   logic                                 slot_free;

   assign raw_abs = req_value[itbd_pkg::VALUE_BITS-1]
                    ? (~req_value + 1'b1) : req_value;

   always_comb begin
      if (digit_base < itbd_pkg::RADIX_MIN) begin
         radix_in = itbd_pkg::RADIX_MIN;
      end else if (digit_base > itbd_pkg::RADIX_MAX) begin
         radix_in = itbd_pkg::RADIX_MAX;
      end else begin
         radix_in = digit_base;
      end
   end

   // restoring division, BITS_PER_STEP dividend bits per cycle, MSB first
   always_comb begin
      rem_v = rem_ff;
      qbits = '0;
      for (int k = 0; k < itbd_pkg::BITS_PER_STEP; k++) begin
         rem_v = {rem_v[itbd_pkg::RADIX_BITS-2:0], mag_ff[itbd_pkg::MAG_BITS-1-k]};
         if (rem_v >= radix_ff) begin
            rem_v = rem_v - radix_ff;
            qbits[itbd_pkg::BITS_PER_STEP-1-k] = 1'b1;
         end
      end
      quot = (mag_ff << itbd_pkg::BITS_PER_STEP)
             | itbd_pkg::MAG_BITS'(qbits);
   end

   always_comb begin
      mag_in = mag_ff;
      rem_in = rem_ff;
      if (cmd.load) begin
         mag_in = itbd_pkg::MAG_BITS'(raw_abs);
         rem_in = '0;
      end else if (cmd.div_step) begin
         mag_in = quot;
         rem_in = cmd.div_last ? '0 : rem_v;
      end
   end

   assign ndig_dec  = ndig_ff - 1'b1;
   assign top_digit = digits_ff[ndig_dec[itbd_pkg::DIGIT_IDX_BITS-1:0]];

   always_comb begin
      ndig_in = ndig_ff;
      if (cmd.load) begin
         ndig_in = '0;
      end else if (cmd.div_step && cmd.div_last) begin
         ndig_in = ndig_ff + 1'b1;
      end else if (cmd.emit_digit) begin
         ndig_in = ndig_dec;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      if (cmd.load) begin
         neg_ff   <= req_value[itbd_pkg::VALUE_BITS-1];
         radix_ff <= radix_in;
      end
      if (cmd.div_step && cmd.div_last) begin
         digits_ff[ndig_ff[itbd_pkg::DIGIT_IDX_BITS-1:0]] <=
            rem_v[itbd_pkg::DIGIT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ndig_ff <= '0;
      end else begin
         ndig_ff <= ndig_in;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff <= cmd.emit_sign || cmd.emit_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free) begin
         if (cmd.emit_sign) begin
            rsp_char_ff <= itbd_pkg::CHAR_MINUS;
            rsp_last_ff <= 1'b0;
         end else begin
            rsp_char_ff <= itbd_pkg::digit_char(top_digit);
            rsp_last_ff <= (ndig_ff == itbd_pkg::DIGIT_CNT_BITS'(1));
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   assign status.quot_zero  = (quot == '0);
   assign status.negative   = neg_ff;
   assign status.last_digit = (ndig_ff == itbd_pkg::DIGIT_CNT_BITS'(1));
   assign status.slot_free  = slot_free;

   `ITBD_ASSERT_NOW(a_pop_nonempty, cmd.emit_digit, ndig_ff != '0)
   `ITBD_ASSERT_NEXT(a_load_clears, cmd.load, (ndig_ff == '0) && (rem_ff == '0))
   `ITBD_ASSERT_NEXT(a_push_counts, cmd.div_step && cmd.div_last,
                     ndig_ff == $past(ndig_ff) + 1'b1)

endmodule

@@ design/itbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// itbd_ctrl
// Controller: sequences capture, digit division, sign and digit output.
// ----------------------------------------------------------------------------
`include "integer_to_base_digits_assert.svh"

module itbd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output itbd_pkg::dp_cmd_type    cmd,
   input  itbd_pkg::dp_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_SIGN   = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   localparam logic [itbd_pkg::STEP_CNT_BITS-1:0] STEP_LAST =
      itbd_pkg::STEP_CNT_BITS'(itbd_pkg::DIV_CYCLES - 1);

   state_type                           state_ff, state_in;
   logic [itbd_pkg::STEP_CNT_BITS-1:0]  step_ff, step_in;

   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == ST_IDLE) && req_valid;
      cmd.div_step   = (state_ff == ST_DIVIDE);
      cmd.div_last   = (state_ff == ST_DIVIDE) && (step_ff == STEP_LAST);
      cmd.emit_sign  = (state_ff == ST_SIGN) && status.slot_free;
      cmd.emit_digit = (state_ff == ST_EMIT) && status.slot_free;
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (cmd.div_last) begin
               step_in = '0;
               if (status.quot_zero) begin
                  state_in = status.negative ? ST_SIGN : ST_EMIT;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SIGN: begin
            if (status.slot_free) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.slot_free && status.last_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   `ITBD_ASSERT_NEXT(a_load_divides, cmd.load, state_ff == ST_DIVIDE)
   `ITBD_ASSERT_NOW(a_sign_when_neg, cmd.emit_sign, status.negative)
   `ITBD_ASSERT_NEXT(a_last_to_idle, cmd.emit_digit && status.last_digit,
                     state_ff == ST_IDLE)

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: integer_to_base_digits testbench
// Sends signed integers through the request channel, converts each one into
// its expected characters in the current radix, and compares every character
// on the response channel in order. Covers radix clamping, the most negative
// value, decimal and radix two, backpressure and random traffic.
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      logic [itbd_pkg::CHAR_BITS-1:0] code;
      logic                           last;
   } char_entry_type;

   localparam logic [4:0]                      BASE_AT_RESET  = 5'd16;
   localparam logic [4:0]                      LOWEST_BASE    = 5'd2;
   localparam logic [4:0]                      HIGHEST_BASE   = 5'd16;
   localparam logic [itbd_pkg::CHAR_BITS-1:0]  ASCII_DASH     = "-";
   localparam logic [itbd_pkg::CHAR_BITS-1:0]  ASCII_ZERO     = "0";
   localparam logic [itbd_pkg::CHAR_BITS-1:0]  ASCII_A        = "a";
   localparam logic [itbd_pkg::VALUE_BITS-1:0] MOST_NEGATIVE  = 32'h8000_0000;
   localparam logic [itbd_pkg::VALUE_BITS-1:0] MOST_POSITIVE  = 32'h7fff_ffff;
   localparam int                              STALL_LIMIT    = 3000;
   localparam int                              LONG_HOLD      = 400;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [itbd_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [itbd_pkg::CSR_DATA_BITS-1:0] pwdata;
   logic [itbd_pkg::CSR_DATA_BITS-1:0] prdata;
   logic pready;

   itbd_req_if req_bus ();
   itbd_rsp_if rsp_bus ();

   integer_to_base_digits dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   char_entry_type expected_chars[$];
   logic [4:0]     base_setting;
   int             errors;
   bit             sender_gaps;
   bit             rsp_stalls;
   int             hold_request;
   int             quiet_cycles;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected text of one value in the current radix
   function automatic void queue_text_of(input logic [itbd_pkg::VALUE_BITS-1:0] v);
      logic [4:0]                      radix;
      logic [itbd_pkg::VALUE_BITS-1:0] mag;
      logic [3:0]                      digs[$];
      char_entry_type                  c;
      logic                            negative;
      int                              i;
      radix = base_setting;
      if (radix < LOWEST_BASE) radix = LOWEST_BASE;
      if (radix > HIGHEST_BASE) radix = HIGHEST_BASE;
      negative = v[itbd_pkg::VALUE_BITS-1];
      mag = negative ? (~v + 1'b1) : v;
      if (mag == '0) begin
         c.code = ASCII_ZERO;
         c.last = 1'b1;
         expected_chars.push_back(c);
         return;
      end
      while (mag != '0) begin
         digs.push_back(4'(mag % radix));
         mag = mag / radix;
      end
      if (negative) begin
         c.code = ASCII_DASH;
         c.last = 1'b0;
         expected_chars.push_back(c);
      end
      for (i = digs.size() - 1; i >= 0; i--) begin
         c.code = (digs[i] < 4'd10) ? ASCII_ZERO + digs[i] : ASCII_A + (digs[i] - 4'd10);
         c.last = (i == 0);
         expected_chars.push_back(c);
      end
   endfunction

   function automatic logic [itbd_pkg::VALUE_BITS-1:0] random_value();
      logic [itbd_pkg::VALUE_BITS-1:0] v;
      longint                          p;
      int                              r;
      int                              k;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = $urandom_range(0, 40);
         2: v = MOST_POSITIVE - $urandom_range(0, 20);
         3: v = $urandom >> $urandom_range(0, 31);
         4: begin
            r = $urandom_range(2, 16);
            k = $urandom_range(1, 31);
            p = 1;
            while (k > 0 && p * r < 64'h8000_0000) begin
               p = p * r;
               k--;
            end
            v = itbd_pkg::VALUE_BITS'(p) + itbd_pkg::VALUE_BITS'($urandom_range(0, 2))
                - 1'b1;
         end
         default: v = $urandom_range(0, 1);
      endcase
      if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
      return v;
   endfunction

   task automatic send_value(input logic [itbd_pkg::VALUE_BITS-1:0] v);
      int gap;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      queue_text_of(v);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write the radix, then read it back
   task automatic set_digit_base(input logic [itbd_pkg::CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {itbd_pkg::REG_DIGIT_BASE, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      base_setting = data[4:0];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== itbd_pkg::CSR_DATA_BITS'(base_setting)) begin
         $display("%0t: digit_base readback expected %h actual %h",
                  $time, itbd_pkg::CSR_DATA_BITS'(base_setting), prdata);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [itbd_pkg::CSR_DATA_BITS-1:0] base_word(input logic [4:0] base);
      logic [itbd_pkg::CSR_DATA_BITS-1:0] w;
      w = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      w[4:0] = base;
      return w;
   endfunction

   task automatic test_reset_base();
      send_value('0);
      send_value(32'd1);
      send_value(32'hffff_ffff);
      send_value(MOST_POSITIVE);
      send_value(MOST_NEGATIVE);
      send_value(32'd255);
      send_value(-32'sd16);
      wait_idle();
   endtask

   task automatic test_radix_two();
      set_digit_base(32'd2);
      send_value(MOST_NEGATIVE);
      send_value(MOST_POSITIVE);
      send_value('0);
      send_value(32'hffff_ffff);
      send_value(32'd5);
      wait_idle();
   endtask

   task automatic test_decimal();
      set_digit_base(32'd10);
      send_value(MOST_NEGATIVE);
      send_value(MOST_POSITIVE);
      send_value(-32'sd7);
      send_value(32'd10);
      send_value('0);
      wait_idle();
   endtask

   task automatic test_radix_clamping();
      set_digit_base(32'd0);
      send_value(32'd6);
      wait_idle();
      set_digit_base(32'd1);
      send_value(32'd3);
      wait_idle();
      set_digit_base(32'd17);
      send_value(32'd255);
      wait_idle();
      set_digit_base(32'hffff_ffff);
      send_value(-32'sd171);
      wait_idle();
   endtask

   // long response hold-off while requests keep coming, a full drain, then a batch with sender gaps
   task automatic test_backpressure();
      set_digit_base(32'd8);
      sender_gaps  = 1'b0;
      hold_request = LONG_HOLD;
      repeat (20) send_value(random_value());
      wait_idle();
      sender_gaps = 1'b1;
      repeat (10) send_value(random_value());
      wait_idle();
   endtask

   task automatic test_random_bases();
      logic [4:0] base;
      repeat (6) begin
         base = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(2, 16));
         set_digit_base(base_word(base));
         sender_gaps = ($urandom_range(0, 3) != 0);
         rsp_stalls  = ($urandom_range(0, 3) != 0);
         repeat (40) send_value(random_value());
         wait_idle();
      end
   endtask

   task automatic test_no_idling();
      sender_gaps = 1'b0;
      rsp_stalls  = 1'b0;
      set_digit_base(base_word(5'($urandom_range(2, 16))));
      repeat (20) send_value(random_value());
      wait_idle();
   endtask

   initial begin : drive_rsp_ready
      int n;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request != 0) begin
            n = hold_request;
            hold_request = 0;
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (rsp_stalls && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_chars
      char_entry_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected transfer, expected none actual char %h last %b",
                     $time, rsp_bus.char_code, rsp_bus.last_char);
            errors++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_bus.char_code !== want.code) begin
               $display("%0t: char_code expected %h actual %h",
                        $time, want.code, rsp_bus.char_code);
               errors++;
            end
            if (rsp_bus.last_char !== want.last) begin
               $display("%0t: last_char expected %b actual %b",
                        $time, want.last, rsp_bus.last_char);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("integer_to_base_digits test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      errors       = 0;
      hold_request = 0;
      quiet_cycles = 0;
      sender_gaps  = 1'b1;
      rsp_stalls   = 1'b1;
      base_setting = BASE_AT_RESET;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_base();
      test_radix_two();
      test_decimal();
      test_radix_clamping();
      test_backpressure();
      test_random_bases();
      test_no_idling();
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_chars.size() == 0) begin
         $display("integer_to_base_digits test passed");
      end else begin
         $display("integer_to_base_digits test failed");
      end
      $finish;
   end
endmodule
